FILE: rtl/core/assert_macros.svh
// Assertion helpers for the core RTL.
// Define ASSERT_OFF to compile all assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/tlcd_pkg.sv
package tlcd_pkg;

    // Request kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_CHAR    = 2'd0;
    localparam t_kind KIND_CURSOR  = 2'd1;
    localparam t_kind KIND_NORMAL  = 2'd2;
    localparam t_kind KIND_INVERSE = 2'd3;

    typedef logic [7:0] t_byte;

    // Geometry defaults
    localparam int COLUMNS_DEF    = 96;
    localparam int TEXT_LINES_DEF = 8;

    // Glyph layout
    localparam int GLYPH_COLS  = 5;
    localparam int CHAR_WORDS  = GLYPH_COLS + 1;
    localparam int CHAR_ADVANCE = CHAR_WORDS;
    localparam int MAX_WORDS   = CHAR_WORDS;
    localparam int WIDX_W      = $clog2(MAX_WORDS);
    localparam int GLYPH_W     = 8 * GLYPH_COLS;
    localparam int FONT_DEPTH  = 96;

    // Controller command bytes
    localparam t_byte CMD_COL_LO   = 8'h00;
    localparam t_byte CMD_COL_HI   = 8'h10;
    localparam t_byte CMD_PAGE     = 8'hB0;
    localparam t_byte CMD_MODE     = 8'hA0;
    localparam t_byte MODE_DISPLAY = 8'h06;
    localparam t_byte MODE_INVERSE = 8'h01;
    localparam t_byte MASK_COL_LO  = 8'h0F;
    localparam t_byte MASK_COL_HI  = 8'h07;
    localparam t_byte MASK_PAGE    = 8'h0F;
    localparam t_byte BLANK_BYTE   = 8'h00;
    localparam t_byte FIRST_PRINT  = 8'h20;

    // One output word without the framing bit
    typedef struct packed {
        logic  is_data;
        t_byte payload;
    } t_word;

    // 5x7 font, printable codes 0x20..0x7F; column 0 in the top byte.
    localparam logic [GLYPH_W-1:0] FONT [FONT_DEPTH] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h0000000000
    };

endpackage

FILE: rtl/core/tlcd_req_if.sv
interface tlcd_req_if;
    import tlcd_pkg::*;

    logic  valid;
    logic  ready;
    t_kind kind;
    t_byte char_code;
    t_byte cursor_x;
    t_byte cursor_y;

    modport source (output valid, kind, char_code, cursor_x, cursor_y, input ready);
    modport sink   (input valid, kind, char_code, cursor_x, cursor_y, output ready);
endinterface

FILE: rtl/core/tlcd_word_if.sv
interface tlcd_word_if;
    import tlcd_pkg::*;

    logic  valid;
    logic  ready;
    logic  is_data;
    t_byte payload;
    logic  last;

    modport source (output valid, is_data, payload, last, input ready);
    modport sink   (input valid, is_data, payload, last, output ready);
endinterface

FILE: rtl/core/text_lcd_command_generator.sv
// Text-mode command generator for a COLUMNS x TEXT_LINES monochrome LCD.
// Input channel i_req carries one request item: kind, char_code, cursor_x,
// cursor_y. Output channel o_word carries controller words: is_data, payload
// and last, the latter marking the final word of one request's burst.
//   write character : six data words (five glyph columns, then a blank)
//   set cursor      : three command words (column low, column high, page)
//   normal/inverse  : one mode command word
// A character code of 0x80 or above is taken and produces nothing.
// Latency: the first word of a burst is valid the cycle after the request
// is taken. Words then leave at one per cycle while o_word.ready is high.
// Bursts: one request per burst, held in the single burst register, so a new
// request is taken only while idle or as the current burst's last word goes.
// The next request is taken in the same cycle the last word of the current
// burst is taken, so bursts run back to back with no gap.
// Stall: while o_word.ready is low the current word holds and i_req.ready
// stays low once a burst is pending.
// Reset (i_rst_n low, synchronous): cursor goes to column 0, line 0 and any
// pending burst is dropped.
module text_lcd_command_generator #(
    parameter int COLUMNS    = tlcd_pkg::COLUMNS_DEF,
    parameter int TEXT_LINES = tlcd_pkg::TEXT_LINES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tlcd_req_if.sink       i_req,
    tlcd_word_if.source    o_word
);
    import tlcd_pkg::*;

    `include "assert_macros.svh"

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int LINE_W = (TEXT_LINES > 1) ? $clog2(TEXT_LINES) : 1;

    typedef logic [COL_W-1:0]  t_xmod_tab [256];
    typedef logic [LINE_W-1:0] t_ymod_tab [256];

    // Modulo reduction tables for the 8-bit cursor fields, built at elaboration.
    function automatic t_xmod_tab build_xmod();
        t_xmod_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = COL_W'(i % COLUMNS);
        end
        return tab;
    endfunction

    function automatic t_ymod_tab build_ymod();
        t_ymod_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = LINE_W'(i % TEXT_LINES);
        end
        return tab;
    endfunction

    localparam t_xmod_tab XMOD = build_xmod();
    localparam t_ymod_tab YMOD = build_ymod();

    // Cursor state
    logic [COL_W-1:0]  r_col,  n_col;
    logic [LINE_W-1:0] r_line, n_line;

    // Burst register: the words of one request, drained one per cycle while o_word.ready is high
    logic              r_busy;
    logic [WIDX_W-1:0] r_idx;
    logic [WIDX_W-1:0] r_last_idx, n_last_idx;
    t_word             r_words [MAX_WORDS];
    t_word             n_words [MAX_WORDS];

    logic w_out_fire, w_done, w_in_fire, w_has_words;
    logic [6:0]         w_glyph_idx;
    logic [GLYPH_W-1:0] w_glyph;
    logic [COL_W:0]     w_col_adv;
    logic [COL_W-1:0]   w_col_step;
    logic [COL_W-1:0]   w_set_col;
    logic [LINE_W-1:0]  w_set_line;
    t_byte              w_col8, w_line8;

    // Handshake
    assign w_out_fire  = r_busy & o_word.ready;
    assign w_done      = w_out_fire & (r_idx == r_last_idx);
    assign i_req.ready = ~r_busy | w_done;
    assign w_in_fire   = i_req.valid & i_req.ready;
    assign w_has_words = ~((i_req.kind == KIND_CHAR) & i_req.char_code[7]);

    assign o_word.valid   = r_busy;
    assign o_word.is_data = r_words[r_idx].is_data;
    assign o_word.payload = r_words[r_idx].payload;
    assign o_word.last    = (r_idx == r_last_idx);

    // Glyph fetch; control codes draw as a space
    assign w_glyph_idx = (i_req.char_code >= FIRST_PRINT)
                       ? (i_req.char_code[6:0] - FIRST_PRINT[6:0]) : 7'd0;
    assign w_glyph     = FONT[w_glyph_idx];

    // Column advance with wrap
    assign w_col_adv  = {1'b0, r_col} + (COL_W + 1)'(CHAR_ADVANCE);
    assign w_col_step = (w_col_adv >= (COL_W + 1)'(COLUMNS))
                      ? COL_W'(w_col_adv - (COL_W + 1)'(COLUMNS))
                      : COL_W'(w_col_adv);

    assign w_set_col  = XMOD[i_req.cursor_x];
    assign w_set_line = YMOD[i_req.cursor_y];
    assign w_col8     = 8'(w_set_col);
    assign w_line8    = 8'(w_set_line);

    always_comb begin
        n_col      = r_col;
        n_line     = r_line;
        n_last_idx = '0;
        for (int i = 0; i < MAX_WORDS; i++) begin
            n_words[i] = '0;
        end
        case (i_req.kind)
            KIND_CHAR: begin
                for (int i = 0; i < GLYPH_COLS; i++) begin
                    n_words[i] = '{is_data: 1'b1,
                                   payload: w_glyph[GLYPH_W-1-8*i -: 8]};
                end
                n_words[GLYPH_COLS] = '{is_data: 1'b1, payload: BLANK_BYTE};
                n_last_idx = WIDX_W'(CHAR_WORDS - 1);
                n_col      = w_col_step;
                if (w_col_step == '0) begin
                    n_line = (r_line == LINE_W'(TEXT_LINES - 1)) ? '0 : r_line + 1'b1;
                end
            end
            KIND_CURSOR: begin
                n_col      = w_set_col;
                n_line     = w_set_line;
                n_words[0] = '{is_data: 1'b0, payload: CMD_COL_LO | (w_col8 & MASK_COL_LO)};
                n_words[1] = '{is_data: 1'b0,
                               payload: CMD_COL_HI | ((w_col8 >> 4) & MASK_COL_HI)};
                n_words[2] = '{is_data: 1'b0, payload: CMD_PAGE | (w_line8 & MASK_PAGE)};
                n_last_idx = WIDX_W'(2);
            end
            KIND_NORMAL: begin
                n_words[0] = '{is_data: 1'b0, payload: CMD_MODE | MODE_DISPLAY};
            end
            default: begin
                n_words[0] = '{is_data: 1'b0,
                               payload: CMD_MODE | MODE_DISPLAY | MODE_INVERSE};
            end
        endcase
    end

    // Control and cursor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_col  <= '0;
            r_line <= '0;
        end else if (w_in_fire) begin
            r_busy <= w_has_words;
            r_idx  <= '0;
            if (w_has_words) begin
                r_col  <= n_col;
                r_line <= n_line;
            end
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (w_out_fire) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Burst payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_last_idx <= n_last_idx;
            for (int i = 0; i < MAX_WORDS; i++) begin
                r_words[i] <= n_words[i];
            end
        end
    end

    // A word taken that is not the last keeps the burst going
    `ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, w_out_fire && !o_word.last, o_word.valid)
    // A request with words starts its burst at word zero
    `ASSERT_NEXT(a_burst_start, i_clk, i_rst_n, w_in_fire && w_has_words, r_busy && r_idx == '0)
    // Word index never runs past the burst end
    `ASSERT_IMPLY(a_idx_bound, i_clk, i_rst_n, r_busy, r_idx <= r_last_idx)
    // Cursor column stays on screen
    `ASSERT_IMPLY(a_col_range, i_clk, i_rst_n, 1'b1, {1'b0, r_col} < (COL_W + 1)'(COLUMNS))

endmodule
